// ===== design/knps_pkg.sv =====
// Shared types and constants for the k-nearest point select block.
package knps_pkg;

  localparam int unsigned COORD_W        = 24;
  localparam int unsigned DIFF_W         = COORD_W + 1;
  localparam int unsigned SQ_W           = 2 * DIFF_W;
  localparam int unsigned DIST_W         = 50;
  localparam int unsigned NIDX_W         = 6;
  localparam int unsigned MAXN_W         = 6;
  localparam int unsigned MAX_POINTS_DEF = 64;

  localparam logic [MAXN_W-1:0] MAXN_RESET = MAXN_W'(7);
  localparam logic [DIST_W-1:0] DIST_SAT   = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      is_reference;
    logic                      set_end;
  } in_item_t;

  typedef struct packed {
    logic [NIDX_W-1:0] neighbour_index;
    logic [DIST_W-1:0] distance_sq;
    logic              found;
    logic              final_result;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Control from the sequencer to the minimum search.
  typedef struct packed {
    logic clear;   // forget the current best
    logic filter;  // only keys ranked after the previous pick count
  } scan_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_DIST = 3'b010,
    ST_SCAN = 3'b100
  } knps_state_e;

endpackage

// ===== design/knps_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module knps_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/knps_dist_calc.sv =====
// Two-stage squared Euclidean distance pipeline: square, then sum.
module knps_dist_calc #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [IDX_W-1:0]              in_idx_i,
  input  knps_pkg::point_t              point_i,
  input  knps_pkg::point_t              ref_i,
  output logic                          out_valid_o,
  output logic [IDX_W-1:0]              out_idx_o,
  output logic [knps_pkg::DIST_W-1:0]   dist_o,
  output logic                          busy_o
);

  logic signed [knps_pkg::DIFF_W-1:0] dx, dy, dz;
  logic signed [knps_pkg::SQ_W-1:0]   sqx, sqy, sqz;
  logic [knps_pkg::SQ_W-1:0]          sqx_q, sqy_q, sqz_q;
  logic [knps_pkg::SQ_W+1:0]          sum;
  logic [knps_pkg::DIST_W-1:0]        dist_d, dist_q;
  logic                               v1_q, v2_q;
  logic [IDX_W-1:0]                   idx1_q, idx2_q;

  always_comb begin
    dx  = $signed({point_i.x[knps_pkg::COORD_W-1], point_i.x})
        - $signed({ref_i.x[knps_pkg::COORD_W-1], ref_i.x});
    dy  = $signed({point_i.y[knps_pkg::COORD_W-1], point_i.y})
        - $signed({ref_i.y[knps_pkg::COORD_W-1], ref_i.y});
    dz  = $signed({point_i.z[knps_pkg::COORD_W-1], point_i.z})
        - $signed({ref_i.z[knps_pkg::COORD_W-1], ref_i.z});
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
  end

  // Saturate the sum at the largest distance code.
  always_comb begin
    sum = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
    if (sum > {2'b00, knps_pkg::DIST_SAT}) begin
      dist_d = knps_pkg::DIST_SAT;
    end else begin
      dist_d = sum[knps_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= $unsigned(sqx);
    sqy_q  <= $unsigned(sqy);
    sqz_q  <= $unsigned(sqz);
    idx1_q <= in_idx_i;
    dist_q <= dist_d;
    idx2_q <= idx1_q;
  end

  assign out_valid_o = v2_q;
  assign out_idx_o   = idx2_q;
  assign dist_o      = dist_q;
  assign busy_o      = v1_q | v2_q;

endmodule

// ===== design/knps_min_scan.sv =====
// Running minimum over a stream of (distance, index) keys, with a lower bound.
module knps_min_scan #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  knps_pkg::scan_ctrl_t        ctrl_i,
  input  logic                        smp_valid_i,
  input  logic [IDX_W-1:0]            smp_idx_i,
  input  logic [knps_pkg::DIST_W-1:0] smp_dist_i,
  input  logic [IDX_W-1:0]            prev_idx_i,
  input  logic [knps_pkg::DIST_W-1:0] prev_dist_i,
  output logic [IDX_W-1:0]            best_idx_o,
  output logic [knps_pkg::DIST_W-1:0] best_dist_o
);

  logic                        have_q;
  logic [IDX_W-1:0]            best_idx_q;
  logic [knps_pkg::DIST_W-1:0] best_dist_q;
  logic                        after_prev;
  logic                        better;
  logic                        take;

  // Keys arrive in index order, so a strict less-than keeps the earliest tie.
  always_comb begin
    after_prev = !ctrl_i.filter
              || (smp_dist_i > prev_dist_i)
              || ((smp_dist_i == prev_dist_i) && (smp_idx_i > prev_idx_i));
    better     = !have_q || (smp_dist_i < best_dist_q);
    take       = smp_valid_i && after_prev && better;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      priority if (ctrl_i.clear) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= smp_idx_i;
      best_dist_q <= smp_dist_i;
    end
  end

  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;

endmodule

// ===== design/k_nearest_point_select_top.sv =====
// Top level of the k-nearest point select block: load, distance pass, ranking scans.
// Selection: on set_end, a distance pass over the stored points is followed by one
//   ranking scan over the distance memory per result.
// Throughput: one transaction per cycle while loading and the output is free;
//   selection, or a result held by out_stall_i, blocks new input.
// Reset: store empty, reference cleared, max_neighbours back to 7; no clearing pass.
module k_nearest_point_select_top #(
  parameter int unsigned MAX_POINTS = knps_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  knps_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output knps_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [knps_pkg::MAXN_W-1:0]     cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (CNT_W > knps_pkg::MAXN_W) ? CNT_W : knps_pkg::MAXN_W;
  localparam int unsigned PT_W  = $bits(knps_pkg::point_t);

  // Control state.
  knps_pkg::knps_state_e        state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         ref_seen_q, ref_seen_d;
  logic [knps_pkg::MAXN_W-1:0]  maxn_q;
  logic [knps_pkg::MAXN_W-1:0]  limit_q, limit_d;
  logic [knps_pkg::MAXN_W-1:0]  round_q, round_d;
  logic [CNT_W-1:0]             rd_addr_q, rd_addr_d;
  logic                         rd_valid_q, rd_valid_d;
  logic                         out_valid_q, out_valid_d;

  // Payload.
  knps_pkg::point_t             ref_q, ref_d;
  logic [IDX_W-1:0]             rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]             prev_idx_q, prev_idx_d;
  logic [knps_pkg::DIST_W-1:0]  prev_dist_q, prev_dist_d;
  knps_pkg::out_item_t          out_item_q, out_item_d;

  // Datapath wires.
  knps_pkg::point_t             in_point;
  knps_pkg::point_t             pt_rdata;
  logic [PT_W-1:0]              pt_rdata_raw;
  logic [knps_pkg::DIST_W-1:0]  dist_rdata;
  logic                         accept;
  logic                         full;
  logic [CNT_W-1:0]             count_after;
  logic [CMP_W-1:0]             cnt_m1;
  logic [knps_pkg::MAXN_W-1:0]  limit_new;
  logic                         issue;
  logic                         out_free;
  logic                         dc_valid;
  logic [IDX_W-1:0]             dc_idx;
  logic [knps_pkg::DIST_W-1:0]  dc_dist;
  logic                         dc_busy;
  logic                         dist_done;
  logic                         scan_done;
  logic                         smp_valid;
  logic [IDX_W-1:0]             smp_idx;
  logic [knps_pkg::DIST_W-1:0]  smp_dist;
  logic [IDX_W-1:0]             best_idx;
  logic [knps_pkg::DIST_W-1:0]  best_dist;
  knps_pkg::scan_ctrl_t         scan_ctrl;

  assign in_point.x = in_item_i.pos_x;
  assign in_point.y = in_item_i.pos_y;
  assign in_point.z = in_item_i.pos_z;
  assign pt_rdata   = knps_pkg::point_t'(pt_rdata_raw);

  // Take input only while loading, and only when a result could be placed if needed.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != knps_pkg::ST_LOAD) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Points past capacity are dropped; their set_end still counts.
  assign full        = (count_q == CNT_W'(MAX_POINTS));
  assign count_after = full ? count_q : count_q + CNT_W'(1);
  assign cnt_m1      = CMP_W'(count_after) - CMP_W'(1);

  always_comb begin
    if (count_after <= CNT_W'(1)) begin
      limit_new = '0;
    end else if (cnt_m1 > CMP_W'(maxn_q)) begin
      limit_new = maxn_q;
    end else begin
      limit_new = cnt_m1[knps_pkg::MAXN_W-1:0];
    end
  end

  // Sweep the stored entries in load order; one read issued per cycle.
  assign issue = ((state_q == knps_pkg::ST_DIST) || (state_q == knps_pkg::ST_SCAN))
              && (rd_addr_q != count_q);

  // A pass is over once every issued read has reached the minimum search.
  assign dist_done = (state_q == knps_pkg::ST_DIST) && (rd_addr_q == count_q)
                  && !rd_valid_q && !dc_busy;
  assign scan_done = (state_q == knps_pkg::ST_SCAN) && (rd_addr_q == count_q)
                  && !rd_valid_q;

  // The distance pass feeds the search from the pipeline, the scans from the memory.
  always_comb begin
    if (state_q == knps_pkg::ST_DIST) begin
      smp_valid = dc_valid;
      smp_idx   = dc_idx;
      smp_dist  = dc_dist;
    end else begin
      smp_valid = rd_valid_q && (state_q == knps_pkg::ST_SCAN);
      smp_idx   = rd_idx_q;
      smp_dist  = dist_rdata;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ref_seen_d  = ref_seen_q;
    ref_d       = ref_q;
    limit_d     = limit_q;
    round_d     = round_q;
    rd_addr_d   = rd_addr_q;
    rd_valid_d  = issue;
    rd_idx_d    = rd_addr_q[IDX_W-1:0];
    prev_idx_d  = prev_idx_q;
    prev_dist_d = prev_dist_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.filter = (state_q == knps_pkg::ST_SCAN);

    if (issue) begin
      rd_addr_d = rd_addr_q + CNT_W'(1);
    end

    unique case (state_q)
      knps_pkg::ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            // The first point stands in as reference until a marked point shows up.
            if (in_item_i.is_reference || (count_q == '0 && !ref_seen_q)) begin
              ref_d = in_point;
            end
            if (in_item_i.is_reference) begin
              ref_seen_d = 1'b1;
            end
            count_d = count_after;
          end
          if (in_item_i.set_end) begin
            if (limit_new == '0) begin
              // Nothing to report: emit the not-found transaction and start over.
              out_valid_d = 1'b1;
              out_item_d.neighbour_index = '0;
              out_item_d.distance_sq     = '0;
              out_item_d.found           = 1'b0;
              out_item_d.final_result    = 1'b1;
              count_d    = '0;
              ref_seen_d = 1'b0;
            end else begin
              limit_d         = limit_new;
              rd_addr_d       = '0;
              scan_ctrl.clear = 1'b1;
              state_d         = knps_pkg::ST_DIST;
            end
          end
        end
      end
      knps_pkg::ST_DIST: begin
        if (dist_done) begin
          // The overall nearest entry is skipped; it bounds the first scan.
          prev_idx_d      = best_idx;
          prev_dist_d     = best_dist;
          round_d         = knps_pkg::MAXN_W'(1);
          rd_addr_d       = '0;
          scan_ctrl.clear = 1'b1;
          state_d         = knps_pkg::ST_SCAN;
        end
      end
      knps_pkg::ST_SCAN: begin
        if (scan_done && out_free) begin
          out_valid_d = 1'b1;
          out_item_d.neighbour_index = knps_pkg::NIDX_W'(best_idx);
          out_item_d.distance_sq     = best_dist;
          out_item_d.found           = 1'b1;
          out_item_d.final_result    = (round_q == limit_q);
          prev_idx_d  = best_idx;
          prev_dist_d = best_dist;
          if (round_q == limit_q) begin
            count_d    = '0;
            ref_seen_d = 1'b0;
            state_d    = knps_pkg::ST_LOAD;
          end else begin
            round_d         = round_q + knps_pkg::MAXN_W'(1);
            rd_addr_d       = '0;
            scan_ctrl.clear = 1'b1;
          end
        end
      end
      default: begin
        state_d = knps_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knps_pkg::ST_LOAD;
      count_q     <= '0;
      ref_seen_q  <= 1'b0;
      ref_q       <= '0;
      maxn_q      <= knps_pkg::MAXN_RESET;
      limit_q     <= '0;
      round_q     <= '0;
      rd_addr_q   <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ref_seen_q  <= ref_seen_d;
      ref_q       <= ref_d;
      limit_q     <= limit_d;
      round_q     <= round_d;
      rd_addr_q   <= rd_addr_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        maxn_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    prev_idx_q  <= prev_idx_d;
    prev_dist_q <= prev_dist_d;
    out_item_q  <= out_item_d;
  end

  // Point store: written while loading, read during the distance pass. The two
  // never overlap, so no forwarding is needed.
  knps_ram #(
    .WIDTH  (PT_W),
    .DEPTH  (MAX_POINTS),
    .ADDR_W (IDX_W)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (PT_W'(in_point)),
    .re_i    (issue && (state_q == knps_pkg::ST_DIST)),
    .raddr_i (rd_addr_q[IDX_W-1:0]),
    .rdata_o (pt_rdata_raw)
  );

  knps_dist_calc #(
    .IDX_W (IDX_W)
  ) u_dist_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_valid_q && (state_q == knps_pkg::ST_DIST)),
    .in_idx_i    (rd_idx_q),
    .point_i     (pt_rdata),
    .ref_i       (ref_q),
    .out_valid_o (dc_valid),
    .out_idx_o   (dc_idx),
    .dist_o      (dc_dist),
    .busy_o      (dc_busy)
  );

  // Distance cache: filled by the distance pass, read by every ranking scan.
  knps_ram #(
    .WIDTH  (knps_pkg::DIST_W),
    .DEPTH  (MAX_POINTS),
    .ADDR_W (IDX_W)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dc_valid && (state_q == knps_pkg::ST_DIST)),
    .waddr_i (dc_idx),
    .wdata_i (dc_dist),
    .re_i    (issue && (state_q == knps_pkg::ST_SCAN)),
    .raddr_i (rd_addr_q[IDX_W-1:0]),
    .rdata_o (dist_rdata)
  );

  knps_min_scan #(
    .IDX_W (IDX_W)
  ) u_min_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .smp_valid_i (smp_valid),
    .smp_idx_i   (smp_idx),
    .smp_dist_i  (smp_dist),
    .prev_idx_i  (prev_idx_q),
    .prev_dist_i (prev_dist_q),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the k-nearest point select block.
module testbench;
  import knps_pkg::*;

  localparam int          MAX_PTS    = 64;
  localparam int          NO_CFG     = -1;
  localparam int unsigned RAND_ITEMS = 270;
  localparam int unsigned CALM_AT    = RAND_ITEMS - 60;
  localparam int unsigned LONG_HOLD  = 600;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned DRAIN      = 200;
  localparam longint      RUN_LIMIT  = 64'd60_000_000;

  typedef enum int unsigned {SPREAD, CLUSTER, EXTREME, MIXED} coord_style_e;

  // A fixed result typed into a directed row replaces the predicted one.
  typedef struct {
    bit        preset;
    out_item_t res;
  } item_note_t;

  typedef struct {
    int        cfg;
    in_item_t  item;
    bit        preset;
    out_item_t res;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [MAXN_W-1:0]   cfg_wdata_i;

  // Mirror of the block: point store, reference and register.
  point_t              pts [MAX_PTS];
  point_t              ref_pt = '0;
  int unsigned         pt_count = 0;
  bit                  ref_marked = 1'b0;
  logic [MAXN_W-1:0]   nbr_limit = MAXN_RESET;

  out_item_t           expected_q [$];
  item_note_t          item_notes [$];
  plan_row_t           plan [$];

  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;
  bit                  hold_done = 1'b0;
  int unsigned         mismatches = 0;
  int unsigned         n_points = 0;
  int unsigned         n_sets = 0;
  int unsigned         n_checked = 0;
  int unsigned         n_cfg = 0;

  k_nearest_point_select_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Count every mismatch, print only the first ten.
  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic plan_row_t mk_row(input int cfg, input int x, input int y, input int z,
                                       input bit mark, input bit last, input bit preset = 1'b0,
                                       input int idx = 0, input longint dist_val = 0,
                                       input bit found = 1'b0, input bit fin = 1'b0);
    plan_row_t r;
    r.cfg                 = cfg;
    r.item.pos_x          = COORD_W'(x);
    r.item.pos_y          = COORD_W'(y);
    r.item.pos_z          = COORD_W'(z);
    r.item.is_reference   = mark;
    r.item.set_end        = last;
    r.preset              = preset;
    r.res.neighbour_index = NIDX_W'(idx);
    r.res.distance_sq     = DIST_W'(dist_val);
    r.res.found           = found;
    r.res.final_result    = fin;
    return r;
  endfunction

  // Append one row to the stimulus table.
  function automatic void add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic [COORD_W-1:0] draw_coord(input coord_style_e style,
                                                    input logic [COORD_W-1:0] centre);
    coord_style_e s;
    s = (style == MIXED) ? coord_style_e'($urandom_range(0, 2)) : style;
    case (s)
      SPREAD:  return COORD_W'($urandom());
      CLUSTER: return centre + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      default: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(COORD_W-1){1'b0}}};
          1:       return {1'b0, {(COORD_W-1){1'b1}}};
          2:       return '0;
          3:       return '1;
          default: return COORD_W'(1);
        endcase
      end
    endcase
  endfunction

  // Load one accepted point; on set end, rank the set and queue the neighbours.
  task automatic take_point(input in_item_t it);
    item_note_t        note;
    out_item_t         picks [$];
    out_item_t         r;
    point_t            p;
    logic [DIST_W-1:0] dist_tab [MAX_PTS];
    bit                taken [MAX_PTS];
    longint            dx, dy, dz, acc;
    int unsigned       lim, best;
    bit                have;

    note.preset = 1'b0;
    note.res    = '0;
    if (item_notes.size() != 0) note = item_notes.pop_front();
    n_points++;

    // Drop points beyond capacity, marks included.
    if (pt_count < MAX_PTS) begin
      p.x = it.pos_x;
      p.y = it.pos_y;
      p.z = it.pos_z;
      if (it.is_reference || (pt_count == 0 && !ref_marked)) ref_pt = p;
      if (it.is_reference) ref_marked = 1'b1;
      pts[pt_count] = p;
      pt_count++;
    end
    if (!it.set_end) return;

    n_sets++;
    lim = 0;
    if (pt_count > 1) lim = (pt_count - 1 > nbr_limit) ? nbr_limit : pt_count - 1;

    if (lim == 0) begin
      r = '0;
      r.final_result = 1'b1;
      picks.insert(picks.size(), r);
    end else begin
      for (int i = 0; i < pt_count; i++) begin
        dx  = longint'(pts[i].x) - longint'(ref_pt.x);
        dy  = longint'(pts[i].y) - longint'(ref_pt.y);
        dz  = longint'(pts[i].z) - longint'(ref_pt.z);
        acc = dx * dx + dy * dy + dz * dz;
        if (acc > longint'(DIST_SAT)) acc = longint'(DIST_SAT);
        dist_tab[i] = DIST_W'(acc);
        taken[i]    = 1'b0;
      end
      // Pass zero picks the first-ranked entry, which is skipped.
      for (int unsigned pass = 0; pass <= lim; pass++) begin
        best = 0;
        have = 1'b0;
        for (int unsigned i = 0; i < pt_count; i++) begin
          if (!taken[i] && (!have || dist_tab[i] < dist_tab[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        taken[best] = 1'b1;
        if (pass > 0) begin
          r.neighbour_index = NIDX_W'(best);
          r.distance_sq     = dist_tab[best];
          r.found           = 1'b1;
          r.final_result    = (pass == lim);
          picks.insert(picks.size(), r);
        end
      end
    end

    pt_count   = 0;
    ref_marked = 1'b0;
    if (note.preset) begin
      picks.delete();
      picks.insert(0, note.res);
    end
    foreach (picks[i]) expected_q.insert(expected_q.size(), picks[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_checked++;
    if (expected_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result idx=%0d dist=%0d found=%0b final=%0b",
                              got.neighbour_index, got.distance_sq, got.found,
                              got.final_result));
      return;
    end
    want = expected_q.pop_front();
    if (got.neighbour_index !== want.neighbour_index)
      flag_mismatch($sformatf("neighbour_index exp %0d got %0d",
                              want.neighbour_index, got.neighbour_index));
    if (got.distance_sq !== want.distance_sq)
      flag_mismatch($sformatf("distance_sq exp %0d got %0d",
                              want.distance_sq, got.distance_sq));
    if (got.found !== want.found)
      flag_mismatch($sformatf("found exp %0b got %0b", want.found, got.found));
    if (got.final_result !== want.final_result)
      flag_mismatch($sformatf("final_result exp %0b got %0b",
                              want.final_result, got.final_result));
  endtask

  // Sample both channels and the register port at each edge, before any
  // nonblocking update of the same step lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) nbr_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) take_point(in_item_i);
      if (out_valid_o && !out_stall_i) check_result(out_item_o);
    end
  end

  // Offer one point and hold it until the transaction completes.
  task automatic offer_point(input in_item_t it, input bit preset, input out_item_t res);
    item_note_t note;
    note.preset = preset;
    note.res    = res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    item_notes.insert(item_notes.size(), note);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, wait until every queued result is back, then let the block settle.
  task automatic drain_results(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0 || item_notes.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [MAXN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cfg++;
  endtask

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin : receiver
    int unsigned gap;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("k_nearest_point_select_top verification failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t          it;
    coord_style_e      style;
    logic [COORD_W-1:0] centre;
    int unsigned       set_len, mark_pct, rand_sent;
    logic [MAXN_W-1:0] limit_val;

    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rand_sent   = 0;

    // Directed part, register at its reset value first.
    // Single point: nothing qualifies.
    add_row(mk_row(NO_CFG, 100, -200, 300, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0, 1'b1));
    // Opposite corners: largest possible distance.
    add_row(mk_row(NO_CFG, -8388608, -8388608, -8388608, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, 8388607, 8388607, 8388607, 1'b0, 1'b1,
                   1'b1, 1, 64'd844424829468675, 1'b1, 1'b1));
    // No marked point: the first one is the reference; equal distances tie.
    add_row(mk_row(NO_CFG, 0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 256, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, -256, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 0, 0, 512, 1'b0, 1'b1));
    // Several marked points: the last mark wins.
    add_row(mk_row(NO_CFG, 10, 10, 10, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, 0, 0, 0, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 1000, -1000, 5, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, 990, -1000, 5, 1'b0, 1'b1));
    // Copy of the reference loaded ahead of it: the copy is skipped instead.
    add_row(mk_row(NO_CFG, 7, 7, 7, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 7, 7, 7, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, -7, 7, 7, 1'b0, 1'b1));
    // Zero neighbours allowed: nothing qualifies.
    add_row(mk_row(0, 5, 5, 5, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 6, 6, 6, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0, 1'b1));
    // One neighbour allowed.
    add_row(mk_row(1, 1, 2, 3, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, -1, -2, -3, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, 3, 2, 1, 1'b0, 1'b1));
    // Largest limit, fewer points than it.
    add_row(mk_row(63, 4660, -4660, 22136, 1'b0, 1'b0));
    add_row(mk_row(NO_CFG, -22136, 4660, -1, 1'b1, 1'b0));
    add_row(mk_row(NO_CFG, 11184810, -5592406, 0, 1'b0, 1'b1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg != NO_CFG) begin
        drain_results(SETTLE);
        write_cfg(MAXN_W'(plan[i].cfg));
      end
      offer_point(plan[i].item, plan[i].preset, plan[i].res);
    end

    // Overfull set under the largest limit while the receiver holds off, then
    // keep offering the next set so the block backs up into its input.
    drain_results(SETTLE);
    hold_req = 1'b1;
    centre   = COORD_W'($urandom());
    for (int j = 0; j < 70; j++) begin
      it.pos_x        = draw_coord(MIXED, centre);
      it.pos_y        = draw_coord(MIXED, centre);
      it.pos_z        = draw_coord(MIXED, centre);
      it.is_reference = ($urandom_range(0, 99) < 10);
      it.set_end      = (j == 69);
      offer_point(it, 1'b0, '0);
    end
    for (int j = 0; j < 5; j++) begin
      it.pos_x        = draw_coord(SPREAD, centre);
      it.pos_y        = draw_coord(SPREAD, centre);
      it.pos_z        = draw_coord(SPREAD, centre);
      it.is_reference = (j == 2);
      it.set_end      = (j == 4);
      offer_point(it, 1'b0, '0);
    end

    // Random sets, mostly small, now and then past capacity; register changes
    // only between sets with the block idle.
    while (rand_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results(SETTLE);
        case ($urandom_range(0, 4))
          0:       limit_val = '0;
          1:       limit_val = MAXN_W'(1);
          2:       limit_val = '1;
          default: limit_val = MAXN_W'($urandom_range(2, 10));
        endcase
        write_cfg(limit_val);
      end
      set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 9);
      style   = coord_style_e'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       mark_pct = 0;
        1:       mark_pct = 15;
        default: mark_pct = 50;
      endcase
      centre = COORD_W'($urandom());
      for (int j = 0; j < set_len; j++) begin
        it.pos_x        = draw_coord(style, centre);
        it.pos_y        = draw_coord(style, centre);
        it.pos_z        = draw_coord(style, centre);
        it.is_reference = ($urandom_range(0, 99) < mark_pct);
        it.set_end      = (j == set_len - 1);
        offer_point(it, 1'b0, '0);
        rand_sent++;
        if (rand_sent >= CALM_AT) calm = 1'b1;
      end
    end

    drain_results(DRAIN);
    $display("Covered %0d points in %0d sets, %0d results checked, %0d register writes.",
             n_points, n_sets, n_checked, n_cfg);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("k_nearest_point_select_top verification clean");
    end else begin
      $display("k_nearest_point_select_top verification failed");
    end
    $finish;
  end

endmodule
